// ----- rtl/a64dec_pkg.sv -----
package a64dec_pkg;

   typedef enum logic [6:0] {
      M_UNKNOWN, M_B, M_BL, M_ADR, M_ADRP, M_BCOND, M_CBZ, M_CBNZ, M_TBZ, M_TBNZ,
      M_RET, M_BR, M_BLR, M_ADD, M_ADDS, M_SUB, M_SUBS, M_CMN, M_CMP,
      M_MOVN, M_MOVZ, M_MOVK, M_ADC, M_ADCS, M_SBC, M_SBCS,
      M_AND, M_ORR, M_EOR, M_ANDS, M_BIC, M_ORN, M_EON, M_BICS,
      M_SBFM, M_BFM, M_UBFM, M_CSEL, M_CSINC, M_CSINV, M_CSNEG, M_CSET, M_CSETM,
      M_STP, M_LDP, M_LDPSW, M_STURB, M_STURH, M_STUR, M_LDURB, M_LDURH, M_LDUR,
      M_LDURSB, M_LDURSH, M_LDURSW, M_UDIV, M_SDIV, M_LSLV, M_LSRV, M_ASRV,
      M_SVC, M_MADD, M_MSUB, M_MUL, M_MNEG, M_SMULL, M_UMULL, M_SMULH, M_UMULH,
      M_STRB, M_STRH, M_STR, M_LDRB, M_LDRH, M_LDR,
      M_FMUL, M_FDIV, M_FADD, M_FSUB, M_FMAX, M_FMIN,
      M_FMOV, M_FNEG, M_FCMP, M_FCVTNS, M_FCVTNU, M_SCVTF, M_UCVTF
   } mnem_type;

   typedef enum logic [3:0] {
      F_NONE, F_TARGET, F_REG_TARGET, F_ONE_REG, F_ADDSUB_IMM, F_MOVE_WIDE,
      F_THREE_SHIFT, F_THREE, F_BITFIELD, F_CSEL, F_MEM, F_MEM_FP, F_IMM_ONLY,
      F_FP, F_GP_FROM_FP, F_FP_FROM_GP
   } form_type;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [63:0] fetch_address;
   } req_type;

   typedef struct packed {
      logic [6:0]  mnemonic_code;
      logic [3:0]  operand_form;
      logic [4:0]  reg_dest;
      logic [4:0]  reg_first;
      logic [4:0]  reg_second;
      logic [4:0]  reg_third;
      logic [31:0] imm_main;
      logic [5:0]  imm_small;
      logic [3:0]  cond_or_kind;
      logic [2:0]  width_flags;
      logic [63:0] branch_target;
      logic        has_target;
   } rsp_type;

   // decode result before the target add
   typedef struct packed {
      rsp_type     r;
      logic [63:0] base;
      logic [63:0] offset;
   } pre_type;

endpackage

// ----- rtl/a64dec_if.sv -----
interface a64dec_req_if;
   import a64dec_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface a64dec_rsp_if;
   import a64dec_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/a64dec_core.sv -----
module a64dec_core
   import a64dec_pkg::*;
(
   input  logic [31:0] word,
   input  logic [63:0] pc,
   output pre_type     pre
);

   always_comb begin
      logic [4:0]  rd, rn, rm, ra;
      logic [1:0]  wsf, szv, opcv;
      logic [5:0]  op6;
      logic [2:0]  op54;
      logic [3:0]  cnd;
      logic        sf, done;
      logic [63:0] off;
      rd   = word[4:0];
      rn   = word[9:5];
      rm   = word[20:16];
      ra   = word[14:10];
      sf   = word[31];
      wsf  = {sf, sf};
      szv  = word[31:30];
      opcv = word[23:22];
      op6  = word[15:10];
      op54 = word[23:21];
      cnd  = word[15:12];
      off  = '0;
      done = 1'b1;
      pre  = '0;
      pre.base = pc;
      if ((word & 32'h7c000000) == 32'h14000000) begin
         pre.r.mnemonic_code = sf ? M_BL : M_B;
         pre.r.operand_form = F_TARGET;
         off = {{36{word[25]}}, word[25:0], 2'b00};
         pre.r.has_target = 1'b1;
      end else if ((word & 32'h1f000000) == 32'h10000000) begin
         off = {{43{word[23]}}, word[23:5], word[30:29]};
         pre.r.mnemonic_code = sf ? M_ADRP : M_ADR;
         pre.r.operand_form = F_REG_TARGET;
         pre.r.reg_dest = rd;
         pre.r.width_flags = 3'd3;
         pre.r.has_target = 1'b1;
         if (sf) begin
            pre.base = {pc[63:12], 12'h000};
            pre.r.imm_main = off[31:0];
            off = {off[51:0], 12'h000};
         end
      end else if ((word & 32'hff000010) == 32'h54000000) begin
         pre.r.mnemonic_code = M_BCOND;
         pre.r.operand_form = F_TARGET;
         pre.r.cond_or_kind = word[3:0];
         off = {{43{word[23]}}, word[23:5], 2'b00};
         pre.r.has_target = 1'b1;
      end else if ((word & 32'h7e000000) == 32'h34000000) begin
         pre.r.mnemonic_code = word[24] ? M_CBNZ : M_CBZ;
         pre.r.operand_form = F_REG_TARGET;
         pre.r.reg_dest = rd;
         pre.r.width_flags = {1'b0, wsf};
         off = {{43{word[23]}}, word[23:5], 2'b00};
         pre.r.has_target = 1'b1;
      end else if ((word & 32'h7e000000) == 32'h36000000) begin
         pre.r.mnemonic_code = word[24] ? M_TBNZ : M_TBZ;
         pre.r.operand_form = F_REG_TARGET;
         pre.r.reg_dest = rd;
         pre.r.imm_small = {word[31], word[23:19]};
         pre.r.width_flags = {1'b0, wsf};
         off = {{48{word[18]}}, word[18:5], 2'b00};
         pre.r.has_target = 1'b1;
      end else if ((word & 32'hfffffc1f) == 32'hd65f0000) begin
         pre.r.mnemonic_code = M_RET;
         pre.r.operand_form = F_ONE_REG;
         pre.r.reg_first = rn;
         pre.r.width_flags = 3'd3;
      end else if ((word & 32'hffdffc1f) == 32'hd61f0000) begin
         pre.r.mnemonic_code = word[21] ? M_BLR : M_BR;
         pre.r.operand_form = F_ONE_REG;
         pre.r.reg_first = rn;
         pre.r.width_flags = 3'd3;
      end else begin
         done = 1'b0;
      end
      if (!done) begin
         pre.r.reg_dest = rd;
         pre.r.reg_first = rn;
         pre.r.width_flags = {1'b0, wsf};
         done = 1'b1;
         if ((word & 32'h1f000000) == 32'h11000000) begin
            pre.r.mnemonic_code = 7'(M_ADD + {word[30], word[29]});
            if (word[29] && rd == 5'd31)
               pre.r.mnemonic_code = word[30] ? M_CMP : M_CMN;
            pre.r.operand_form = F_ADDSUB_IMM;
            pre.r.imm_main = word[22] ? {8'd0, word[21:10], 12'd0}
                                      : {20'd0, word[21:10]};
         end else if ((word & 32'h1f800000) == 32'h12800000) begin
            pre.r.mnemonic_code = word[30:29] == 2'd0 ? M_MOVN
                               : (word[30:29] == 2'd2 ? M_MOVZ : M_MOVK);
            pre.r.operand_form = F_MOVE_WIDE;
            pre.r.reg_first = '0;
            pre.r.imm_main = {16'd0, word[20:5]};
            pre.r.imm_small = {word[22:21], 4'd0};
         end else if ((word & 32'h1f000000) == 32'h0b000000) begin
            pre.r.mnemonic_code = 7'(M_ADD + {word[30], word[29]});
            pre.r.operand_form = F_THREE_SHIFT;
            pre.r.reg_second = rm;
            pre.r.cond_or_kind = {2'd0, word[23:22]};
            pre.r.imm_small = op6;
         end else if ((word & 32'h1fe0fc00) == 32'h1a000000) begin
            pre.r.mnemonic_code = 7'(M_ADC + word[30:29]);
            pre.r.operand_form = F_THREE;
            pre.r.reg_second = rm;
         end else if ((word & 32'h1f000000) == 32'h0a000000) begin
            pre.r.mnemonic_code = 7'(M_AND + {word[21], word[30:29]});
            pre.r.operand_form = F_THREE;
            pre.r.reg_second = rm;
         end else if ((word & 32'h1f800000) == 32'h13000000 && word[30:29] != 2'd3)
         begin
            pre.r.mnemonic_code = 7'(M_SBFM + word[30:29]);
            pre.r.operand_form = F_BITFIELD;
            pre.r.imm_main = {26'd0, word[21:16]};
            pre.r.imm_small = op6;
         end else if ((word & 32'h1f800000) == 32'h12000000) begin
            pre.r.mnemonic_code = 7'(M_AND + word[30:29]);
            pre.r.operand_form = F_BITFIELD;
            pre.r.cond_or_kind = {3'd0, word[22]};
            pre.r.imm_main = {26'd0, word[21:16]};
            pre.r.imm_small = op6;
         end else if ((word & 32'h1fe00000) == 32'h1a800000) begin
            pre.r.mnemonic_code = 7'(M_CSEL + {word[30], word[10]});
            if (rn == 5'd31 && rm == 5'd31 && word[30] != word[10]) begin
               pre.r.mnemonic_code = word[30] ? M_CSETM : M_CSET;
               if (cnd[3:1] != 3'b111) cnd[0] = ~cnd[0];
            end
            pre.r.operand_form = F_CSEL;
            pre.r.reg_second = rm;
            pre.r.cond_or_kind = cnd;
         end else if ((word & 32'h3f000000) == 32'h29000000 && szv != 2'd3) begin
            pre.r.mnemonic_code = !word[22] ? M_STP : (szv == 2'd1 ? M_LDPSW : M_LDP);
            pre.r.operand_form = F_MEM;
            pre.r.width_flags = {2'b01, szv == 2'd2 || (word[22] && szv == 2'd1)};
            pre.r.reg_third = ra;
            pre.r.imm_main = szv == 2'd2 ? {{22{word[21]}}, word[21:15], 3'd0}
                                          : {{23{word[21]}}, word[21:15], 2'd0};
         end else begin
            done = 1'b0;
         end
         if (!done && (word & 32'h3b200c00) == 32'h38000000) begin
            pre.r.imm_main = {{23{word[20]}}, word[20:12]};
            pre.r.width_flags = {2'b01, szv == 2'd3 || opcv == 2'd2};
            done = 1'b1;
            if (word[26]) begin
               if (!opcv[1] && szv[1]) begin
                  pre.r.mnemonic_code = opcv[0] ? M_LDUR : M_STUR;
                  pre.r.operand_form = F_MEM_FP;
                  pre.r.width_flags = szv == 2'd3 ? 3'd6 : 3'd2;
               end else done = 1'b0;
            end else begin
               pre.r.operand_form = F_MEM;
               if (opcv == 2'd0)
                  pre.r.mnemonic_code = 7'(M_STURB + (szv[1] ? 2'd2 : szv));
               else if (opcv == 2'd1)
                  pre.r.mnemonic_code = 7'(M_LDURB + (szv[1] ? 2'd2 : szv));
               else if (opcv == 2'd2 && szv != 2'd3)
                  pre.r.mnemonic_code = 7'(M_LDURSB + szv);
               else if (opcv == 2'd3 && !szv[1]) begin
                  pre.r.mnemonic_code = 7'(M_LDURSB + szv);
                  pre.r.width_flags = 3'd2;
               end else done = 1'b0;
            end
            if (!done) begin
               pre.r.imm_main = '0;
               pre.r.operand_form = F_NONE;
               pre.r.width_flags = {1'b0, wsf};
            end
         end
         if (!done && (word & 32'h7fe00000) == 32'h1ac00000) begin
            done = 1'b1;
            pre.r.operand_form = F_THREE;
            pre.r.reg_second = rm;
            unique case (op6)
               6'd2:    pre.r.mnemonic_code = M_UDIV;
               6'd3:    pre.r.mnemonic_code = M_SDIV;
               6'd8:    pre.r.mnemonic_code = M_LSLV;
               6'd9:    pre.r.mnemonic_code = M_LSRV;
               6'd10:   pre.r.mnemonic_code = M_ASRV;
               default: begin
                  done = 1'b0;
                  pre.r.operand_form = F_NONE;
                  pre.r.reg_second = '0;
               end
            endcase
         end
         if (!done && (word & 32'hffe0001f) == 32'hd4000001) begin
            done = 1'b1;
            pre.r = '0;
            pre.r.mnemonic_code = M_SVC;
            pre.r.operand_form = F_IMM_ONLY;
            pre.r.imm_main = {16'd0, word[20:5]};
         end
         if (!done && (word & 32'h1f000000) == 32'h1b000000) begin
            done = 1'b1;
            if (op54 == 3'd0)
               pre.r.mnemonic_code = 7'((ra == 5'd31 ? M_MUL : M_MADD) + word[15]);
            else if (sf && ra == 5'd31 && (op54 == 3'd1 || op54 == 3'd5)) begin
               pre.r.mnemonic_code = op54 == 3'd1 ? M_SMULL : M_UMULL;
               pre.r.width_flags = 3'd1;
            end else if (sf && ra == 5'd31 && (op54 == 3'd2 || op54 == 3'd6))
               pre.r.mnemonic_code = op54 == 3'd2 ? M_SMULH : M_UMULH;
            else done = 1'b0;
            if (done) begin
               pre.r.operand_form = F_THREE;
               pre.r.reg_second = rm;
               pre.r.reg_third = ra;
            end else pre.r.width_flags = {1'b0, wsf};
         end
         if (!done && (word & 32'h3b000000) == 32'h39000000) begin
            done = 1'b1;
            pre.r.mnemonic_code = 7'(M_STRB + (szv[1] ? 2'd2 : szv) + (word[22] ? 2'd3 : 2'd0));
            pre.r.operand_form = F_MEM;
            pre.r.width_flags = {2'b01, szv == 2'd3};
            pre.r.imm_main = 32'({20'd0, word[21:10]} << szv);
         end
         if (!done && (word & 32'h1f000000) == 32'h1e000000
             && op6[1:0] == 2'd2 && op6 <= 6'd22) begin
            done = 1'b1;
            pre.r.mnemonic_code = 7'(M_FMUL + op6[5:2]);
            pre.r.operand_form = F_FP;
            pre.r.reg_second = rm;
            pre.r.width_flags = opcv == 2'd1 ? 3'd4 : 3'd0;
         end
         if (!done && ((word & 32'hfffffc00) == 32'h9e670000
                       || (word & 32'hfffffc00) == 32'h1e270000)) begin
            done = 1'b1;
            pre.r.mnemonic_code = M_FMOV;
            pre.r.operand_form = F_FP_FROM_GP;
            pre.r.width_flags = sf ? 3'd6 : 3'd0;
         end
         if (!done && ((word & 32'hfffffc00) == 32'h9e660000
                       || (word & 32'hfffffc00) == 32'h1e260000)) begin
            done = 1'b1;
            pre.r.mnemonic_code = M_FMOV;
            pre.r.operand_form = F_GP_FROM_FP;
            pre.r.width_flags = sf ? 3'd5 : 3'd0;
         end
         if (!done && (word & 32'hffbefc00) == 32'h1e204000) begin
            done = 1'b1;
            pre.r.mnemonic_code = word[16] ? M_FNEG : M_FMOV;
            pre.r.operand_form = F_FP;
            pre.r.width_flags = {word[22], 2'b00};
         end
         if (!done && (word & 32'hffa0fc1f) == 32'h1e202000) begin
            done = 1'b1;
            pre.r.mnemonic_code = M_FCMP;
            pre.r.operand_form = F_FP;
            pre.r.reg_dest = '0;
            pre.r.reg_second = rm;
            pre.r.width_flags = {word[22], 2'b00};
         end
         if (!done && (word & 32'h7f22fc00) == 32'h1e200000) begin
            done = 1'b1;
            pre.r.mnemonic_code = word[16] ? M_FCVTNU : M_FCVTNS;
            pre.r.operand_form = F_GP_FROM_FP;
            pre.r.width_flags = {word[22], 1'b0, sf};
         end
         if (!done && (word & 32'h7f22fc00) == 32'h1e220000) begin
            done = 1'b1;
            pre.r.mnemonic_code = word[16] ? M_UCVTF : M_SCVTF;
            pre.r.operand_form = F_FP_FROM_GP;
            pre.r.width_flags = {word[22], sf, 1'b0};
         end
         if (!done) pre.r = '0;
      end else if (pre.r.mnemonic_code != M_ADRP) begin
         pre.r.imm_main = off[31:0];
      end
      pre.offset = pre.r.has_target ? off : '0;
      if (!pre.r.has_target) pre.base = '0;
   end

endmodule

// ----- rtl/aarch64_subset_instruction_decoder.sv -----
// Decodes one A64 instruction word per clock. The pattern match, the field
// extraction and the 64-bit target add sit in one combinational stage between
// the input register and the result register. An accepted item waits in the
// input register and then moves into the result register, where it is offered
// to the sink. One item per cycle flows through as long as the sink keeps up.
// The input and result registers each hold one word. Ready drops only when
// both registers are full and the sink is stalling.
module aarch64_subset_instruction_decoder
   import a64dec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   a64dec_req_if.sink   req,
   a64dec_rsp_if.source rsp
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   pre_type pre;
   logic    adv_out, take_in;

   a64dec_core u_core (
      .word   (in_ff.instruction_word),
      .pc     (in_ff.fetch_address),
      .pre    (pre)
   );

   assign adv_out = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign take_in = req.valid && req.ready;
   assign req.ready = !in_valid_ff || adv_out;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      out_in = pre.r;
      out_in.branch_target = pre.base + pre.offset;
      out_valid_in = adv_out || (out_valid_ff && !rsp.ready);
      in_valid_in = take_in || (in_valid_ff && !adv_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take_in) in_ff <= req.payload;
      if (adv_out) out_ff <= out_in;
   end

endmodule

// ----- rtl/a64dec_checker.sv -----
module a64dec_checker
   import a64dec_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a held word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mnemonic_code == M_UNKNOWN |->
      rsp_payload.operand_form == F_NONE && !rsp_payload.has_target)
      else $error("unknown word with fields set");

   a_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.has_target |->
      rsp_payload.operand_form == F_TARGET || rsp_payload.operand_form == F_REG_TARGET)
      else $error("target on wrong form");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled input with empty output");

endmodule

bind aarch64_subset_instruction_decoder a64dec_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

// ----- test/a64dec_tb_if.sv -----
// the channel interfaces are shared with the rtl folder

// ----- test/tb_aarch64_subset_instruction_decoder.sv -----
module tb_aarch64_subset_instruction_decoder;
   import a64dec_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;
   localparam int N_RANDOM = 1750;

   logic clock = 1'b0;
   logic reset = 1'b1;
   a64dec_req_if req ();
   a64dec_rsp_if rsp ();

   aarch64_subset_instruction_decoder u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] word;
      logic [63:0] addr;
      bit          has_fixed;
      rsp_type     fixed;
   } row_type;

   rsp_type decodes_due[$];
   int      n_errors = 0;
   int      n_words = 0;
   int      n_decoded = 0;
   int      cycle = 0;
   bit      hold_rsp = 1'b0;
   bit      quiet = 1'b0;
   bit      mnem_seen[128];

   function automatic logic [63:0] sext(logic [63:0] v, int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      v = v & ((m << 1) - 64'd1);
      return (v ^ m) - m;
   endfunction

   function automatic rsp_type zero_rsp();
      rsp_type r;
      r = '0;
      return r;
   endfunction

   // one word through the pattern list, first match wins
   function automatic rsp_type decode_word(logic [31:0] w, logic [63:0] pc);
      rsp_type     r;
      logic [63:0] off;
      logic        sf;
      logic [2:0]  wsf;
      int          op, op2, cond, sz, opc, ld, s2, code;
      logic        wide;
      r = '0;
      sf = w[31];
      wsf = sf ? 3'd3 : 3'd0;
      if ((w & 32'h7c000000) == 32'h14000000) begin
         r.mnemonic_code = sf ? M_BL : M_B;
         r.operand_form = F_TARGET;
         off = sext(w[25:0], 26) << 2;
         r.imm_main = off[31:0];
         r.branch_target = pc + off;
         r.has_target = 1'b1;
         return r;
      end
      if ((w & 32'h1f000000) == 32'h10000000) begin
         off = sext({w[23:5], w[30:29]}, 21);
         r.mnemonic_code = sf ? M_ADRP : M_ADR;
         r.operand_form = F_REG_TARGET;
         r.reg_dest = w[4:0];
         r.imm_main = off[31:0];
         r.width_flags = 3'd3;
         r.branch_target = sf ? ((pc & ~64'hfff) + (off << 12)) : pc + off;
         r.has_target = 1'b1;
         return r;
      end
      if ((w & 32'hff000010) == 32'h54000000) begin
         r.mnemonic_code = M_BCOND;
         r.operand_form = F_TARGET;
         r.cond_or_kind = w[3:0];
         off = sext(w[23:5], 19) << 2;
         r.imm_main = off[31:0];
         r.branch_target = pc + off;
         r.has_target = 1'b1;
         return r;
      end
      if ((w & 32'h7e000000) == 32'h34000000) begin
         r.mnemonic_code = w[24] ? M_CBNZ : M_CBZ;
         r.operand_form = F_REG_TARGET;
         r.reg_dest = w[4:0];
         r.width_flags = wsf;
         off = sext(w[23:5], 19) << 2;
         r.imm_main = off[31:0];
         r.branch_target = pc + off;
         r.has_target = 1'b1;
         return r;
      end
      if ((w & 32'h7e000000) == 32'h36000000) begin
         r.mnemonic_code = w[24] ? M_TBNZ : M_TBZ;
         r.operand_form = F_REG_TARGET;
         r.reg_dest = w[4:0];
         r.imm_small = {w[31], w[23:19]};
         r.width_flags = w[31] ? 3'd3 : 3'd0;
         off = sext(w[18:5], 14) << 2;
         r.imm_main = off[31:0];
         r.branch_target = pc + off;
         r.has_target = 1'b1;
         return r;
      end
      if ((w & 32'hfffffc1f) == 32'hd65f0000) begin
         r.mnemonic_code = M_RET; r.operand_form = F_ONE_REG;
         r.reg_first = w[9:5]; r.width_flags = 3'd3;
         return r;
      end
      if ((w & 32'hfffffc1f) == 32'hd61f0000 || (w & 32'hfffffc1f) == 32'hd63f0000) begin
         r.mnemonic_code = w[21] ? M_BLR : M_BR; r.operand_form = F_ONE_REG;
         r.reg_first = w[9:5]; r.width_flags = 3'd3;
         return r;
      end
      r.reg_dest = w[4:0];
      r.reg_first = w[9:5];
      r.width_flags = wsf;
      if ((w & 32'h1f000000) == 32'h11000000) begin
         code = M_ADD + 2 * w[30] + w[29];
         if (w[29] && w[4:0] == 5'd31) code = w[30] ? M_CMP : M_CMN;
         r.mnemonic_code = 7'(code); r.operand_form = F_ADDSUB_IMM;
         r.imm_main = w[22] ? {8'd0, w[21:10], 12'd0} : {20'd0, w[21:10]};
         return r;
      end
      if ((w & 32'h1f800000) == 32'h12800000) begin
         r.mnemonic_code = w[30:29] == 2'd0 ? M_MOVN : (w[30:29] == 2'd2 ? M_MOVZ : M_MOVK);
         r.operand_form = F_MOVE_WIDE;
         r.reg_first = '0;
         r.imm_main = {16'd0, w[20:5]};
         r.imm_small = {w[22:21], 4'd0};
         return r;
      end
      if ((w & 32'h1f000000) == 32'h0b000000) begin
         r.mnemonic_code = 7'(M_ADD + 2 * w[30] + w[29]); r.operand_form = F_THREE_SHIFT;
         r.reg_second = w[20:16]; r.cond_or_kind = {2'd0, w[23:22]};
         r.imm_small = w[15:10];
         return r;
      end
      if ((w & 32'h1fe0fc00) == 32'h1a000000) begin
         r.mnemonic_code = 7'(M_ADC + w[30:29]); r.operand_form = F_THREE;
         r.reg_second = w[20:16];
         return r;
      end
      if ((w & 32'h1f000000) == 32'h0a000000) begin
         r.mnemonic_code = 7'(M_AND + w[30:29] + (w[21] ? 4 : 0)); r.operand_form = F_THREE;
         r.reg_second = w[20:16];
         return r;
      end
      if ((w & 32'h1f800000) == 32'h13000000 && w[30:29] != 2'd3) begin
         r.mnemonic_code = 7'(M_SBFM + w[30:29]); r.operand_form = F_BITFIELD;
         r.imm_main = {26'd0, w[21:16]}; r.imm_small = w[15:10];
         return r;
      end
      if ((w & 32'h1f800000) == 32'h12000000) begin
         r.mnemonic_code = 7'(M_AND + w[30:29]); r.operand_form = F_BITFIELD;
         r.cond_or_kind = {3'd0, w[22]}; r.imm_main = {26'd0, w[21:16]};
         r.imm_small = w[15:10];
         return r;
      end
      if ((w & 32'h1fe00000) == 32'h1a800000) begin
         op = w[30]; op2 = w[10]; cond = w[15:12];
         code = M_CSEL + 2 * op + op2;
         if (w[9:5] == 5'd31 && w[20:16] == 5'd31) begin
            if (op == 0 && op2 == 1) code = M_CSET;
            else if (op == 1 && op2 == 0) code = M_CSETM;
         end
         if ((code == M_CSET || code == M_CSETM) && (cond & 14) != 14) cond = cond ^ 1;
         r.mnemonic_code = 7'(code); r.operand_form = F_CSEL;
         r.reg_second = w[20:16]; r.cond_or_kind = 4'(cond);
         return r;
      end
      if ((w & 32'h3f000000) == 32'h29000000 && w[31:30] != 2'd3) begin
         opc = w[31:30]; ld = w[22];
         wide = opc == 2 || (ld && opc == 1);
         r.mnemonic_code = ld ? (opc == 1 ? M_LDPSW : M_LDP) : M_STP;
         r.operand_form = F_MEM; r.width_flags = {2'b01, wide};
         r.reg_third = w[14:10];
         off = sext(w[21:15], 7) * (opc == 2 ? 8 : 4);
         r.imm_main = off[31:0];
         return r;
      end
      if ((w & 32'h3b200c00) == 32'h38000000) begin
         sz = w[31:30]; opc = w[23:22]; s2 = sz > 2 ? 2 : sz;
         code = M_UNKNOWN; wide = sz == 3 || opc == 2;
         off = sext(w[20:12], 9);
         r.imm_main = off[31:0];
         if (w[26]) begin
            if (opc < 2 && sz >= 2) begin
               r.mnemonic_code = opc ? M_LDUR : M_STUR; r.operand_form = F_MEM_FP;
               r.width_flags = sz == 3 ? 3'd6 : 3'd2;
               return r;
            end
         end else begin
            if (opc == 0) code = M_STURB + s2;
            else if (opc == 1) code = M_LDURB + s2;
            else if (opc == 2 && sz < 3) code = M_LDURSB + sz;
            else if (opc == 3 && sz < 2) begin code = M_LDURSB + sz; wide = 0; end
            if (code != M_UNKNOWN) begin
               r.mnemonic_code = 7'(code); r.operand_form = F_MEM;
               r.width_flags = {2'b01, wide};
               return r;
            end
         end
         r.imm_main = '0;
      end
      if ((w & 32'h7fe00000) == 32'h1ac00000) begin
         op = w[15:10]; code = M_UNKNOWN;
         case (op)
            2: code = M_UDIV;
            3: code = M_SDIV;
            8: code = M_LSLV;
            9: code = M_LSRV;
            10: code = M_ASRV;
            default: code = M_UNKNOWN;
         endcase
         if (code != M_UNKNOWN) begin
            r.mnemonic_code = 7'(code); r.operand_form = F_THREE; r.reg_second = w[20:16];
            return r;
         end
      end
      if ((w & 32'hffe0001f) == 32'hd4000001) begin
         r = '0;
         r.mnemonic_code = M_SVC; r.operand_form = F_IMM_ONLY;
         r.imm_main = {16'd0, w[20:5]};
         return r;
      end
      if ((w & 32'h1f000000) == 32'h1b000000) begin
         op = w[23:21]; code = M_UNKNOWN;
         if (op == 0) code = (w[14:10] == 5'd31 ? M_MUL : M_MADD) + w[15];
         else if (sf && w[14:10] == 5'd31 && (op == 1 || op == 5)) begin
            code = op == 1 ? M_SMULL : M_UMULL; r.width_flags = 3'd1;
         end else if (sf && w[14:10] == 5'd31 && (op == 2 || op == 6))
            code = op == 2 ? M_SMULH : M_UMULH;
         if (code != M_UNKNOWN) begin
            r.mnemonic_code = 7'(code); r.operand_form = F_THREE;
            r.reg_second = w[20:16]; r.reg_third = w[14:10];
            return r;
         end
         r.width_flags = wsf;
      end
      if ((w & 32'h3b000000) == 32'h39000000) begin
         sz = w[31:30]; s2 = sz > 2 ? 2 : sz;
         r.mnemonic_code = 7'(M_STRB + s2 + 3 * w[22]); r.operand_form = F_MEM;
         r.width_flags = {2'b01, sz == 3};
         r.imm_main = {20'd0, w[21:10]} << sz;
         return r;
      end
      if ((w & 32'h1f000000) == 32'h1e000000) begin
         op = w[15:10];
         if ((op & 3) == 2 && op <= 22) begin
            r.mnemonic_code = 7'(M_FMUL + (op >> 2)); r.operand_form = F_FP;
            r.width_flags = w[23:22] == 2'd1 ? 3'd4 : 3'd0; r.reg_second = w[20:16];
            return r;
         end
      end
      if ((w & 32'hfffffc00) == 32'h9e670000 || (w & 32'hfffffc00) == 32'h1e270000) begin
         r.mnemonic_code = M_FMOV; r.operand_form = F_FP_FROM_GP;
         r.width_flags = sf ? 3'd6 : 3'd0;
         return r;
      end
      if ((w & 32'hfffffc00) == 32'h9e660000 || (w & 32'hfffffc00) == 32'h1e260000) begin
         r.mnemonic_code = M_FMOV; r.operand_form = F_GP_FROM_FP;
         r.width_flags = sf ? 3'd5 : 3'd0;
         return r;
      end
      if ((w & 32'hffbffc00) == 32'h1e204000 || (w & 32'hffbffc00) == 32'h1e214000) begin
         r.mnemonic_code = w[16] ? M_FNEG : M_FMOV; r.operand_form = F_FP;
         r.width_flags = w[22] ? 3'd4 : 3'd0;
         return r;
      end
      if ((w & 32'hffa0fc1f) == 32'h1e202000) begin
         r.mnemonic_code = M_FCMP; r.operand_form = F_FP; r.reg_dest = '0;
         r.reg_second = w[20:16]; r.width_flags = w[22] ? 3'd4 : 3'd0;
         return r;
      end
      if ((w & 32'h7f22fc00) == 32'h1e200000) begin
         r.mnemonic_code = w[16] ? M_FCVTNU : M_FCVTNS; r.operand_form = F_GP_FROM_FP;
         r.width_flags = {w[22], 1'b0, sf};
         return r;
      end
      if ((w & 32'h7f22fc00) == 32'h1e220000) begin
         r.mnemonic_code = w[16] ? M_UCVTF : M_SCVTF; r.operand_form = F_FP_FROM_GP;
         r.width_flags = {w[22], sf, 1'b0};
         return r;
      end
      return zero_rsp();
   endfunction

   // patterns that reach the decode groups, filled with random fields
   function automatic logic [31:0] likely_word();
      logic [31:0] base [24];
      logic [31:0] mask [24];
      int          k;
      base = '{32'h14000000, 32'h10000000, 32'h54000000, 32'h34000000, 32'h36000000,
               32'hd65f0000, 32'hd61f0000, 32'h11000000, 32'h12800000, 32'h0b000000,
               32'h1a000000, 32'h0a000000, 32'h13000000, 32'h12000000, 32'h1a800000,
               32'h29000000, 32'h38000000, 32'h1ac00000, 32'hd4000001, 32'h1b000000,
               32'h39000000, 32'h1e000800, 32'h1e204000, 32'h1e200000};
      mask = '{32'h7c000000, 32'h1f000000, 32'hff000010, 32'h7e000000, 32'h7e000000,
               32'hfffffc1f, 32'hffdffc1f, 32'h1f000000, 32'h1f800000, 32'h1f000000,
               32'h1fe0fc00, 32'h1f000000, 32'h1f800000, 32'h1f800000, 32'h1fe00000,
               32'h3f000000, 32'h3b200c00, 32'h7fe0f000, 32'hffe0001f, 32'h1f000000,
               32'h3b000000, 32'h1f00f000, 32'hffbefc00, 32'h7f22fc00};
      k = $urandom_range(23);
      return base[k] | ($urandom() & ~mask[k]);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      n_errors++;
      $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
   endtask

   task automatic send_word(logic [31:0] w, logic [63:0] a);
      int gap;
      if (!quiet && $urandom_range(3) == 0) begin
         req.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{instruction_word: w, fetch_address: a};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      decodes_due.push_back(decode_word(w, a));
      n_words++;
   endtask

   // sink side: random stalls, plus a long hold-off when asked
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(4) == 0) begin
            rsp.ready <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle <= cycle + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (decodes_due.size() == 0) begin
            report_mismatch("unexpected word", rsp.payload.mnemonic_code, 0);
         end else begin
            want = decodes_due.pop_front();
            n_decoded++;
            mnem_seen[want.mnemonic_code] = 1'b1;
            if (rsp.payload.mnemonic_code !== want.mnemonic_code)
               report_mismatch("mnemonic", rsp.payload.mnemonic_code, want.mnemonic_code);
            if (rsp.payload.operand_form !== want.operand_form)
               report_mismatch("form", rsp.payload.operand_form, want.operand_form);
            if (rsp.payload.reg_dest !== want.reg_dest)
               report_mismatch("rd", rsp.payload.reg_dest, want.reg_dest);
            if (rsp.payload.reg_first !== want.reg_first)
               report_mismatch("rn", rsp.payload.reg_first, want.reg_first);
            if (rsp.payload.reg_second !== want.reg_second)
               report_mismatch("rm", rsp.payload.reg_second, want.reg_second);
            if (rsp.payload.reg_third !== want.reg_third)
               report_mismatch("ra", rsp.payload.reg_third, want.reg_third);
            if (rsp.payload.imm_main !== want.imm_main)
               report_mismatch("imm", rsp.payload.imm_main, want.imm_main);
            if (rsp.payload.imm_small !== want.imm_small)
               report_mismatch("imm_small", rsp.payload.imm_small, want.imm_small);
            if (rsp.payload.cond_or_kind !== want.cond_or_kind)
               report_mismatch("kind", rsp.payload.cond_or_kind, want.cond_or_kind);
            if (rsp.payload.width_flags !== want.width_flags)
               report_mismatch("width", rsp.payload.width_flags, want.width_flags);
            if (rsp.payload.branch_target !== want.branch_target)
               report_mismatch("target", rsp.payload.branch_target, want.branch_target);
            if (rsp.payload.has_target !== want.has_target)
               report_mismatch("has_target", rsp.payload.has_target, want.has_target);
         end
      end
   end

   initial begin
      @(posedge clock);
      while (cycle < LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      row_type     rows [$];
      row_type     row;
      rsp_type     fx;
      logic [31:0] w;
      logic [63:0] a;
      int          n_kinds;
      req.valid = 1'b0;
      req.payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unknown word: every field zero
      rows.push_back('{32'h00000000, 64'h0, 1'b1, zero_rsp()});
      fx = '0; fx.mnemonic_code = M_RET; fx.operand_form = F_ONE_REG;
      fx.reg_first = 5'd30; fx.width_flags = 3'd3;
      rows.push_back('{32'hd65f03c0, 64'hffffffffffffffff, 1'b1, fx});
      // svc with largest imm16
      fx = '0; fx.mnemonic_code = M_SVC; fx.operand_form = F_IMM_ONLY; fx.imm_main = 32'hffff;
      rows.push_back('{32'hd41fffe1, 64'h0, 1'b1, fx});
      // branch backward from zero wraps the target
      rows.push_back('{32'h17ffffff, 64'h0, 1'b0, fx});
      rows.push_back('{32'h97ffffff, 64'hfffffffffffffffc, 1'b0, fx});
      rows.push_back('{32'h15ffffff, 64'h8000000000000000, 1'b0, fx});
      rows.push_back('{32'hf0ffffff, 64'h123456789abcdfff, 1'b0, fx});
      rows.push_back('{32'h70800000, 64'hffffffffffffffff, 1'b0, fx});
      rows.push_back('{32'h5480000e, 64'h1000, 1'b0, fx});
      rows.push_back('{32'hb4ffffff, 64'h40, 1'b0, fx});
      // tested bit above 31 comes from word bit 31
      rows.push_back('{32'hb7f8001f, 64'h40, 1'b0, fx});
      rows.push_back('{32'hf100fc1f, 64'h0, 1'b0, fx});
      rows.push_back('{32'h31400c1f, 64'h0, 1'b0, fx});
      rows.push_back('{32'hb2a00000, 64'h0, 1'b0, fx});
      rows.push_back('{32'h8bc0fc00, 64'h0, 1'b0, fx});
      // cset with a condition that stays uninverted and two that flip
      rows.push_back('{32'h9a9fe7e0, 64'h0, 1'b0, fx});
      rows.push_back('{32'h5a9f03e1, 64'h0, 1'b0, fx});
      rows.push_back('{32'h1a9f17e2, 64'h0, 1'b0, fx});
      rows.push_back('{32'h73000000, 64'h0, 1'b0, fx});
      rows.push_back('{32'h69400000, 64'h0, 1'b0, fx});
      rows.push_back('{32'hf8c00000, 64'h0, 1'b0, fx});
      rows.push_back('{32'h9b3f7c00, 64'h0, 1'b0, fx});
      rows.push_back('{32'hf97fffff, 64'h0, 1'b0, fx});
      rows.push_back('{32'h1ee03800, 64'h0, 1'b0, fx});
      rows.push_back('{32'h9e670000, 64'h0, 1'b0, fx});

      foreach (rows[i]) begin
         row = rows[i];
         if (row.has_fixed && decode_word(row.word, row.addr) != row.fixed)
            report_mismatch("table row", i, 0);
         send_word(row.word, row.addr);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 500) hold_rsp = 1'b1;
         if (i == 900) begin
            req.valid <= 1'b0;
            while (decodes_due.size() != 0) @(posedge clock);
         end
         if (i == N_RANDOM - 200) quiet = 1'b1;
         w = ($urandom_range(3) == 0) ? $urandom() : likely_word();
         case ($urandom_range(3))
            0: a = 64'hffffffffffffffff - $urandom_range(4095);
            1: a = $urandom_range(4095);
            default: a = {$urandom(), $urandom()};
         endcase
         send_word(w, a);
      end
      req.valid <= 1'b0;
      while (decodes_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      n_kinds = 0;
      foreach (mnem_seen[k]) if (mnem_seen[k]) n_kinds++;
      $display("sent %0d words, decoded %0d over %0d distinct mnemonic codes",
               n_words, n_decoded, n_kinds);
      $display("including stall back-pressure, a drain pause and wrapping targets");
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/a64dec_pkg.sv
rtl/a64dec_if.sv
rtl/a64dec_core.sv
rtl/aarch64_subset_instruction_decoder.sv
rtl/a64dec_checker.sv
test/a64dec_tb_if.sv
test/tb_aarch64_subset_instruction_decoder.sv
